FILE: src/iae_pkg.sv
// Shared constants, codes and types for the infix arithmetic evaluator.
package iae_pkg;

  localparam int VALUE_WIDTH   = 48;
  localparam int FRACTION_BITS = 16;
  localparam int NUM_WIDTH     = 32;

  localparam int ITER_MAX = (VALUE_WIDTH > NUM_WIDTH) ? VALUE_WIDTH : NUM_WIDTH;
  localparam int CNT_W    = $clog2(ITER_MAX);
  localparam int QW       = NUM_WIDTH + FRACTION_BITS;
  localparam int WW       = (QW > VALUE_WIDTH) ? QW : VALUE_WIDTH;

  localparam logic [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_MUL   = 8'h2a;
  localparam logic [7:0] CH_DIV   = 8'h2f;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_MUL  = 2'd1;
  localparam logic [1:0] OP_DIV  = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;
  localparam logic [1:0] ST_UNK  = 2'd3;

  typedef struct packed {
    logic go;
    logic is_div;
  } md_cmd_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } md_rsp_t;

endpackage

FILE: src/iae_muldiv.sv
// Bit-serial saturating multiplier and restoring divider for the open term.
module iae_muldiv (
  input  logic                           clk,
  input  logic                           rst,
  input  iae_pkg::md_cmd_t               cmd,
  input  logic [iae_pkg::VALUE_WIDTH-1:0] term,
  input  logic [iae_pkg::NUM_WIDTH-1:0]   num,
  output iae_pkg::md_rsp_t               rsp,
  output logic [iae_pkg::VALUE_WIDTH-1:0] result
);
  import iae_pkg::*;

  logic                   busy;
  logic                   is_div;
  logic [CNT_W-1:0]       cnt;
  logic [VALUE_WIDTH:0]   prod;
  logic [VALUE_WIDTH-1:0] mcand;
  logic [NUM_WIDTH-1:0]   dsr;
  logic [NUM_WIDTH-1:0]   rem;
  logic [VALUE_WIDTH-1:0] quo;

  logic [VALUE_WIDTH:0]   prod_next;
  logic                   mul_ovf;
  logic [NUM_WIDTH:0]     rem2;
  logic [NUM_WIDTH:0]     rem_sub;
  logic                   ge;
  logic [NUM_WIDTH-1:0]   rem_next;
  logic [VALUE_WIDTH-1:0] quo_next;

  always_comb begin
    prod_next = {prod[VALUE_WIDTH-1:0], 1'b0}
              + (dsr[NUM_WIDTH-1] ? {1'b0, mcand} : '0);
    mul_ovf   = prod_next > {1'b0, VMAX};
    rem2      = {rem, quo[VALUE_WIDTH-1]};
    rem_sub   = rem2 - {1'b0, dsr};
    ge        = rem2 >= {1'b0, dsr};
    rem_next  = ge ? rem_sub[NUM_WIDTH-1:0] : rem2[NUM_WIDTH-1:0];
    quo_next  = {quo[VALUE_WIDTH-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rsp.done <= 1'b0;
      rsp.ovf  <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (cmd.go) begin
        busy   <= 1'b1;
        is_div <= cmd.is_div;
        cnt    <= cmd.is_div ? CNT_W'(VALUE_WIDTH - 1) : CNT_W'(NUM_WIDTH - 1);
        prod   <= '0;
        rem    <= '0;
        quo    <= term;
        mcand  <= term;
        dsr    <= num;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (is_div) begin
          rem <= rem_next;
          quo <= quo_next;
          if (cnt == '0) begin
            busy     <= 1'b0;
            rsp.done <= 1'b1;
            rsp.ovf  <= 1'b0;
            result   <= quo_next;
          end
        end else if (mul_ovf) begin
          // product only grows, so the first excess decides
          busy     <= 1'b0;
          rsp.done <= 1'b1;
          rsp.ovf  <= 1'b1;
          result   <= VMAX;
        end else begin
          prod <= prod_next;
          dsr  <= {dsr[NUM_WIDTH-2:0], 1'b0};
          if (cnt == '0) begin
            busy     <= 1'b0;
            rsp.done <= 1'b1;
            rsp.ovf  <= 1'b0;
            result   <= prod_next[VALUE_WIDTH-1:0];
          end
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_go_idle: assert property (@(posedge clk) disable iff (rst) cmd.go |-> !busy)
    else $error("start while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) rsp.done |=> !rsp.done)
    else $error("done held");
  a_done_end: assert property (@(posedge clk) disable iff (rst) rsp.done |-> !busy)
    else $error("done while busy");
  a_div_no_ovf: assert property (@(posedge clk) disable iff (rst)
    (rsp.done && is_div) |-> !rsp.ovf) else $error("divide flagged overflow");
`endif

endmodule

FILE: src/infix_arithmetic_evaluator_core.sv
// Top level: character decode, term and sum registers, sequencer and output beat.
// Steps: a digit or skipped byte is only decoded; an operator also closes the open term
//   and posts it, and a pending '*' or '/' waits in the serial unit between the two.
// One beat at a time: a new beat is taken only in idle; the 48-step serial divider is the longest wait.
// The last beat runs a final close and fold, then holds the result until taken.
// Reset (rst, synchronous) clears the sum, term, number, flags and sequencer.
module infix_arithmetic_evaluator_core (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [7:0]                             symbol,
  input  logic                                   is_last,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [iae_pkg::VALUE_WIDTH-1:0] value,
  output logic [1:0]                             status
);
  import iae_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DEC   = 3'd1;
  localparam logic [2:0] S_CLOSE = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_POST  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]                    state;
  logic [7:0]                    sym;
  logic                          last;
  logic                          pass2;
  logic [NUM_WIDTH-1:0]          acc;
  logic [VALUE_WIDTH-1:0]        term;
  logic signed [VALUE_WIDTH-1:0] sum;
  logic                          neg;
  logic [1:0]                    pend;
  logic                          started;
  logic [1:0]                    err;

  md_cmd_t                cmd;
  md_rsp_t                rsp;
  logic [VALUE_WIDTH-1:0] md_result;

  logic                   is_digit, is_addsub, is_muldiv, is_skip;
  logic [NUM_WIDTH+3:0]   digit_sum;
  logic                   digit_ovf;
  logic [WW-1:0]          first_q;
  logic                   first_ovf;
  logic                   use_unit;
  logic [VALUE_WIDTH:0]   fold_raw;
  logic                   fold_ovf;
  logic [VALUE_WIDTH-1:0] fold_val;

  iae_muldiv u_md (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .term   (term),
    .num    (acc),
    .rsp    (rsp),
    .result (md_result)
  );

  always_comb begin
    is_digit  = (sym >= CH_ZERO) && (sym <= CH_NINE);
    is_addsub = (sym == CH_PLUS) || (sym == CH_MINUS);
    is_muldiv = (sym == CH_MUL) || (sym == CH_DIV);
    is_skip   = (sym == CH_NUL);
    // acc * 10 + digit as two shifted adds
    digit_sum = ({4'b0, acc} << 3) + ({4'b0, acc} << 1)
              + (NUM_WIDTH + 4)'(sym[3:0]);
    digit_ovf = |digit_sum[NUM_WIDTH+3:NUM_WIDTH];
    first_q   = WW'(acc) << FRACTION_BITS;
    first_ovf = first_q > WW'(VMAX);
    use_unit  = started && ((pend == OP_MUL) || (pend == OP_DIV && acc != '0));
    cmd.go     = (state == S_CLOSE) && use_unit;
    cmd.is_div = (pend == OP_DIV);
    // signed fold with one guard bit
    fold_raw  = neg ? ({sum[VALUE_WIDTH-1], sum} - {1'b0, term})
                    : ({sum[VALUE_WIDTH-1], sum} + {1'b0, term});
    fold_ovf  = fold_raw[VALUE_WIDTH] != fold_raw[VALUE_WIDTH-1];
    fold_val  = fold_ovf ? (neg ? VMIN : VMAX) : fold_raw[VALUE_WIDTH-1:0];
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pass2     <= 1'b0;
      acc       <= '0;
      term      <= '0;
      sum       <= '0;
      neg       <= 1'b0;
      pend      <= OP_NONE;
      started   <= 1'b0;
      err       <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            sym   <= symbol;
            last  <= is_last;
            pass2 <= 1'b0;
            state <= S_DEC;
          end
        end
        S_DEC: begin
          // digits, skipped and unknown bytes end here unless this is the last beat
          if (is_digit) begin
            if (digit_ovf) begin
              acc <= '1;
              if (err == ST_OK) err <= ST_OVF;
            end else begin
              acc <= digit_sum[NUM_WIDTH-1:0];
            end
          end else if (!is_addsub && !is_muldiv && !is_skip) begin
            if (err == ST_OK) err <= ST_UNK;
          end
          if (is_addsub || is_muldiv) begin
            state <= S_CLOSE;
          end else if (last) begin
            pass2 <= 1'b1;
            state <= S_CLOSE;
          end else begin
            state <= S_IDLE;
          end
        end
        S_CLOSE: begin
          if (use_unit) begin
            state <= S_WAIT;
          end else begin
            if (started && pend == OP_DIV) begin
              // divide by zero: a nonzero term saturates
              if (term != '0) term <= VMAX;
              if (err == ST_OK) err <= ST_DIV0;
            end else begin
              term    <= first_ovf ? VMAX : first_q[VALUE_WIDTH-1:0];
              started <= 1'b1;
              if (first_ovf && err == ST_OK) err <= ST_OVF;
            end
            state <= S_POST;
          end
        end
        S_WAIT: begin
          if (rsp.done) begin
            term <= md_result;
            if (rsp.ovf && err == ST_OK) err <= ST_OVF;
            state <= S_POST;
          end
        end
        S_POST: begin
          acc  <= '0;
          pend <= OP_NONE;
          if (pass2) begin
            // emit the folded sum, then drop all expression state
            value     <= fold_val;
            status    <= (fold_ovf && err == ST_OK) ? ST_OVF : err;
            out_valid <= 1'b1;
            sum       <= '0;
            term      <= '0;
            neg       <= 1'b0;
            started   <= 1'b0;
            err       <= ST_OK;
            state     <= S_OUT;
          end else begin
            if (is_muldiv) begin
              pend <= (sym == CH_MUL) ? OP_MUL : OP_DIV;
            end else begin
              sum     <= fold_val;
              term    <= '0;
              started <= 1'b0;
              neg     <= (sym == CH_MINUS);
              if (fold_ovf && err == ST_OK) err <= ST_OVF;
            end
            if (last) begin
              pass2 <= 1'b1;
              state <= S_CLOSE;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_one_side: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input taken while result waits");
  a_out_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == S_OUT)) else $error("result outside output state");
  a_emit_clean: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (sum == '0 && !started && err == ST_OK))
    else $error("state not cleared on emit");
  a_term_range: assert property (@(posedge clk) disable iff (rst)
    !term[VALUE_WIDTH-1]) else $error("term magnitude exceeds range");
`endif

endmodule
